>>> hdl/csr_sparse_matrix_vector_multiply_top_assert.svh
// ---------------------------------------------------------------------------
// CSR SpMV assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CSMV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define CSMV_NEVER(label, clk, rst_n, cond, msg) \
	`CSMV_ASSERT(label, clk, rst_n, !(cond), msg)
`else
`define CSMV_ASSERT(label, clk, rst_n, prop, msg)
`define CSMV_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> hdl/csrspmv_pkg.sv
// ---------------------------------------------------------------------------
// CSR SpMV package
// Types, constants and saturation helpers shared by the SpMV block.
// ---------------------------------------------------------------------------
`default_nettype none
package csrspmv_pkg;
	localparam int DATA_W = 32;
	localparam int ACC_W = 48;
	localparam int PROD_W = 64;
	localparam int IDX_W = 10;
	localparam int ROW_W = 16;
	localparam int FRAC = 16;
	localparam int CMD_W = 2;
	localparam int ADDR_W = 3;
	localparam int APB_W = 32;

	localparam int DEF_VECTOR_DEPTH = 1024;
	localparam int DEF_CMDQ_DEPTH = 4;
	localparam int DEF_OUTQ_DEPTH = 8;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_NONZERO = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

	localparam logic REG_FIRST_ROW = 1'b0;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_MAC,
		OP_EMPTY
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         index;
		logic                     zero_x;
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic [ROW_W-1:0]         row;
	} cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0]         row;
		logic signed [DATA_W-1:0] sum;
	} res_t;

	localparam logic signed [ACC_W-1:0] OUT_MAX_A = 48'sd2147483647;
	localparam logic signed [ACC_W-1:0] OUT_MIN_A = -48'sd2147483648;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] != v[ACC_W-1]) begin
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > OUT_MAX_A) begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < OUT_MIN_A) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

>>> hdl/csrspmv_fifo.sv
// ---------------------------------------------------------------------------
// CSR SpMV queue
// Small register queue used between front and back and for results.
// ---------------------------------------------------------------------------
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_top_assert.svh"
module csrspmv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic                            full,
	input  wire logic                       pop,
	output logic [WIDTH-1:0]                rdata,
	output logic                            empty,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	assign rdata = mem_q[rd_ptr_q];
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign count = count_q;

	`CSMV_ASSERT(a_no_overflow, clk, arst_n, push |-> !full, "queue written while full")
	`CSMV_ASSERT(a_no_underflow, clk, arst_n, pop |-> !empty, "queue read while empty")
	`CSMV_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "queue count past depth")
endmodule
`default_nettype wire

>>> hdl/csrspmv_front.sv
// ---------------------------------------------------------------------------
// CSR SpMV front end
// Accepts items, classifies them and numbers finished rows.
// ---------------------------------------------------------------------------
`default_nettype none
module csrspmv_front #(
	parameter int VECTOR_DEPTH = csrspmv_pkg::DEF_VECTOR_DEPTH
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     push,
	output logic                                          full,
	input  wire logic [csrspmv_pkg::CMD_W-1:0]            command,
	input  wire logic [csrspmv_pkg::IDX_W-1:0]            vector_index,
	input  wire logic signed [csrspmv_pkg::DATA_W-1:0]    vector_value,
	input  wire logic [csrspmv_pkg::IDX_W-1:0]            column_index,
	input  wire logic signed [csrspmv_pkg::DATA_W-1:0]    entry_value,
	input  wire logic                                     row_end,
	input  wire logic [csrspmv_pkg::ROW_W-1:0]            first_row,
	output logic                                          q_push,
	output csrspmv_pkg::cmd_t                             q_entry,
	input  wire logic                                     q_full
);
	localparam logic [16:0] DEPTH_L = 17'(VECTOR_DEPTH);

	logic [csrspmv_pkg::ROW_W-1:0] rows_done_q;
	logic valid_op, emits, accept;

	always_comb begin
		valid_op = 1'b0;
		emits = 1'b0;
		q_entry.op = csrspmv_pkg::OP_LOAD;
		q_entry.index = vector_index;
		q_entry.value = vector_value;
		q_entry.zero_x = 1'b0;
		q_entry.last = row_end;
		q_entry.row = first_row + rows_done_q;
		unique case (command)
			csrspmv_pkg::CMD_LOAD: begin
				valid_op = (17'(vector_index) < DEPTH_L);
			end
			csrspmv_pkg::CMD_NONZERO: begin
				valid_op = 1'b1;
				emits = row_end;
				q_entry.op = csrspmv_pkg::OP_MAC;
				q_entry.index = column_index;
				q_entry.value = entry_value;
				q_entry.zero_x = (17'(column_index) >= DEPTH_L);
			end
			csrspmv_pkg::CMD_EMPTY: begin
				valid_op = 1'b1;
				emits = 1'b1;
				q_entry.op = csrspmv_pkg::OP_EMPTY;
			end
			default: begin
				valid_op = 1'b0;
			end
		endcase
	end

	assign accept = push && !q_full;
	assign q_push = accept && valid_op;
	assign full = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_done_q <= '0;
		end else if (accept && emits) begin
			rows_done_q <= rows_done_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> hdl/csrspmv_back.sv
// ---------------------------------------------------------------------------
// CSR SpMV back end
// Vector store, multiply, rounding and row accumulation pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
`include "csr_sparse_matrix_vector_multiply_top_assert.svh"
module csrspmv_back #(
	parameter int VECTOR_DEPTH = csrspmv_pkg::DEF_VECTOR_DEPTH,
	parameter int OUT_DEPTH = csrspmv_pkg::DEF_OUTQ_DEPTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cmd_empty,
	input  wire csrspmv_pkg::cmd_t                 cmd,
	output logic                                   cmd_pop,
	input  wire logic [$clog2(OUT_DEPTH+1)-1:0]    out_count,
	output logic                                   res_push,
	output csrspmv_pkg::res_t                      res
);
	localparam int AW = $clog2(VECTOR_DEPTH);
	localparam int CW = $clog2(OUT_DEPTH+1);
	localparam int SW = CW + 3;

	logic signed [csrspmv_pkg::DATA_W-1:0] vec_mem [VECTOR_DEPTH];

	logic v_s1, v_s2, v_s3, v_s4;
	csrspmv_pkg::op_t op_s1, op_s2, op_s3, op_s4;
	logic last_s1, last_s2, last_s3;
	logic zx_s1;
	logic [csrspmv_pkg::ROW_W-1:0] row_s1, row_s2, row_s3, row_s4;
	logic signed [csrspmv_pkg::DATA_W-1:0] value_s1, x_s1;
	logic signed [csrspmv_pkg::PROD_W-1:0] prod_s2;
	logic signed [csrspmv_pkg::ACC_W-1:0] rnd_s3, sum_s4, acc_q;
	logic emit_s4;

	logic [AW-1:0] addr;
	logic [SW-1:0] need;
	logic signed [csrspmv_pkg::DATA_W-1:0] xm;
	logic signed [csrspmv_pkg::ACC_W:0] acc_add;
	logic signed [csrspmv_pkg::ACC_W-1:0] acc_sat;
	logic s3_emit;

	// each item in flight may still claim one result slot
	assign need = SW'(out_count) + SW'(v_s1) + SW'(v_s2) + SW'(v_s3) + SW'(v_s4) + 1'b1;
	assign cmd_pop = !cmd_empty && (need <= SW'(OUT_DEPTH));
	assign addr = AW'(cmd.index);

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == csrspmv_pkg::OP_LOAD) vec_mem[addr] <= cmd.value;
		x_s1 <= vec_mem[addr];
	end

	assign xm = zx_s1 ? '0 : x_s1;
	assign acc_add = (csrspmv_pkg::ACC_W+1)'(acc_q) + (csrspmv_pkg::ACC_W+1)'(rnd_s3);
	assign acc_sat = csrspmv_pkg::sat_acc(acc_add);
	assign s3_emit = v_s3 && ((op_s3 == csrspmv_pkg::OP_MAC && last_s3) ||
		op_s3 == csrspmv_pkg::OP_EMPTY);

	always_ff @(posedge clk) begin
		op_s1 <= cmd.op;
		last_s1 <= cmd.last;
		zx_s1 <= cmd.zero_x;
		row_s1 <= cmd.row;
		value_s1 <= cmd.value;
		op_s2 <= op_s1;
		last_s2 <= last_s1;
		row_s2 <= row_s1;
		prod_s2 <= value_s1 * xm;
		op_s3 <= op_s2;
		last_s3 <= last_s2;
		row_s3 <= row_s2;
		rnd_s3 <= csrspmv_pkg::ACC_W'((prod_s2 + 64'sd32768) >>> csrspmv_pkg::FRAC);
		op_s4 <= op_s3;
		row_s4 <= row_s3;
		sum_s4 <= (op_s3 == csrspmv_pkg::OP_EMPTY) ? '0 : acc_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			emit_s4 <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= cmd_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			emit_s4 <= s3_emit;
			if (s3_emit) acc_q <= '0;
			else if (v_s3 && op_s3 == csrspmv_pkg::OP_MAC) acc_q <= acc_sat;
		end
	end

	assign res_push = v_s4 && emit_s4;
	assign res.row = row_s4;
	assign res.sum = csrspmv_pkg::sat_out(sum_s4);

	`CSMV_ASSERT(a_sum_cleared, clk, arst_n, s3_emit |=> (acc_q == '0), "row sum not cleared")
	`CSMV_ASSERT(a_credit, clk, arst_n, need <= SW'(OUT_DEPTH + 1), "result slots overbooked")
	`CSMV_ASSERT(a_empty_zero, clk, arst_n,
		(v_s4 && emit_s4 && op_s4 == csrspmv_pkg::OP_EMPTY) |-> (sum_s4 == '0),
		"empty row with nonzero sum")
endmodule
`default_nettype wire

>>> hdl/csr_sparse_matrix_vector_multiply_top.sv
// ---------------------------------------------------------------------------
// CSR sparse matrix-vector multiply
// Streams y = A*x for a compressed-row matrix against a loaded dense vector.
// ---------------------------------------------------------------------------
// Accepts one item per clock: load items fill the vector store, nonzero items
// each take one multiply-accumulate and empty-row items emit a zero sum. The
// single-port vector store and the single-register accumulate loop set this
// rate; it holds while results are taken, and up to OUTQ_DEPTH results are
// held before full is raised. A row's result passes the back-end stages and
// result queue. The vector store is not cleared: read only entries already
// loaded. first_row sits at byte address 0 and should be written while idle.
`default_nettype none
module csr_sparse_matrix_vector_multiply_top #(
	parameter int VECTOR_DEPTH = csrspmv_pkg::DEF_VECTOR_DEPTH,
	parameter int CMDQ_DEPTH = csrspmv_pkg::DEF_CMDQ_DEPTH,
	parameter int OUTQ_DEPTH = csrspmv_pkg::DEF_OUTQ_DEPTH
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     psel,
	input  wire logic                                     penable,
	input  wire logic                                     pwrite,
	input  wire logic [csrspmv_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [csrspmv_pkg::APB_W-1:0]            pwdata,
	output logic [csrspmv_pkg::APB_W-1:0]                 prdata,
	output logic                                          pready,
	input  wire logic                                     push,
	output logic                                          full,
	input  wire logic [csrspmv_pkg::CMD_W-1:0]            command,
	input  wire logic [csrspmv_pkg::IDX_W-1:0]            vector_index,
	input  wire logic signed [csrspmv_pkg::DATA_W-1:0]    vector_value,
	input  wire logic [csrspmv_pkg::IDX_W-1:0]            column_index,
	input  wire logic signed [csrspmv_pkg::DATA_W-1:0]    entry_value,
	input  wire logic                                     row_end,
	output logic                                          empty,
	input  wire logic                                     pop,
	output logic [csrspmv_pkg::ROW_W-1:0]                 row_index,
	output logic signed [csrspmv_pkg::DATA_W-1:0]         row_sum
);
	localparam int CQW = $bits(csrspmv_pkg::cmd_t);
	localparam int RQW = $bits(csrspmv_pkg::res_t);

	logic [csrspmv_pkg::ROW_W-1:0] first_row_q;
	logic q_push, q_full, q_empty, q_pop;
	csrspmv_pkg::cmd_t q_entry, q_head;
	logic [CQW-1:0] q_rdata;
	logic [$clog2(CMDQ_DEPTH+1)-1:0] q_count;
	logic res_push;
	csrspmv_pkg::res_t res, res_head;
	logic [RQW-1:0] r_rdata;
	logic [$clog2(OUTQ_DEPTH+1)-1:0] r_count;
	logic r_full;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_row_q <= '0;
		end else if (psel && penable && pwrite &&
				paddr[csrspmv_pkg::ADDR_W-1] == csrspmv_pkg::REG_FIRST_ROW) begin
			first_row_q <= pwdata[csrspmv_pkg::ROW_W-1:0];
		end
	end

	assign prdata = (paddr[csrspmv_pkg::ADDR_W-1] == csrspmv_pkg::REG_FIRST_ROW) ?
		csrspmv_pkg::APB_W'(first_row_q) : '0;

	csrspmv_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.vector_index(vector_index),
		.vector_value(vector_value),
		.column_index(column_index),
		.entry_value(entry_value),
		.row_end(row_end),
		.first_row(first_row_q),
		.q_push(q_push),
		.q_entry(q_entry),
		.q_full(q_full)
	);

	csrspmv_fifo #(
		.WIDTH(CQW),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_entry),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty),
		.count(q_count)
	);

	assign q_head = csrspmv_pkg::cmd_t'(q_rdata);

	csrspmv_back #(
		.VECTOR_DEPTH(VECTOR_DEPTH),
		.OUT_DEPTH(OUTQ_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(q_empty || (q_count == '0)),
		.cmd(q_head),
		.cmd_pop(q_pop),
		.out_count(r_count),
		.res_push(res_push),
		.res(res)
	);

	csrspmv_fifo #(
		.WIDTH(RQW),
		.DEPTH(OUTQ_DEPTH)
	) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res),
		.full(r_full),
		.pop(pop && !empty),
		.rdata(r_rdata),
		.empty(empty),
		.count(r_count)
	);

	assign res_head = csrspmv_pkg::res_t'(r_rdata);
	assign row_index = res_head.row;
	assign row_sum = r_full ? res_head.sum : res_head.sum;
endmodule
`default_nettype wire

>>> tb/sv/csr_sparse_matrix_vector_multiply_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CSR SpMV testbench
// Loads dense vector entries and streams sparse rows through the block. Both
// sides stall at random, and the result side holds off once for a long time.
// Every row result is checked against an in-bench multiply-accumulate model
// with Q16.16 rounding and saturation. first_row is swept between phases.
// ---------------------------------------------------------------------------
module csr_sparse_matrix_vector_multiply_top_tb;
	localparam logic [csrspmv_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam logic [csrspmv_pkg::ADDR_W-1:0] FIRST_ROW_ADDR =
		csrspmv_pkg::ADDR_W'(4 * csrspmv_pkg::REG_FIRST_ROW);
	localparam logic [csrspmv_pkg::ADDR_W-1:0] UNMAPPED_ADDR =
		csrspmv_pkg::ADDR_W'(4 * (csrspmv_pkg::REG_FIRST_ROW + 1));
	localparam int DEPTH = csrspmv_pkg::DEF_VECTOR_DEPTH;
	localparam longint ACC_HI = (64'sd1 <<< (csrspmv_pkg::ACC_W - 1)) - 64'sd1;
	localparam longint ACC_LO = -(64'sd1 <<< (csrspmv_pkg::ACC_W - 1));
	localparam longint OUT_HI = 64'sd2147483647;
	localparam longint OUT_LO = -64'sd2147483648;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_AFTER = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 233;

	typedef struct {
		logic [csrspmv_pkg::CMD_W-1:0]         cmd;
		logic [csrspmv_pkg::IDX_W-1:0]         vidx;
		logic signed [csrspmv_pkg::DATA_W-1:0] vval;
		logic [csrspmv_pkg::IDX_W-1:0]         col;
		logic signed [csrspmv_pkg::DATA_W-1:0] ent;
		logic                                  last;
	} spmv_item_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  psel = 1'b0;
	logic                                  penable = 1'b0;
	logic                                  pwrite = 1'b0;
	logic [csrspmv_pkg::ADDR_W-1:0]        paddr = '0;
	logic [csrspmv_pkg::APB_W-1:0]         pwdata = '0;
	logic [csrspmv_pkg::APB_W-1:0]         prdata;
	logic                                  pready;
	logic                                  push = 1'b0;
	logic                                  full;
	logic [csrspmv_pkg::CMD_W-1:0]         command = '0;
	logic [csrspmv_pkg::IDX_W-1:0]         vector_index = '0;
	logic signed [csrspmv_pkg::DATA_W-1:0] vector_value = '0;
	logic [csrspmv_pkg::IDX_W-1:0]         column_index = '0;
	logic signed [csrspmv_pkg::DATA_W-1:0] entry_value = '0;
	logic                                  row_end = 1'b0;
	logic                                  empty;
	logic                                  pop = 1'b0;
	logic [csrspmv_pkg::ROW_W-1:0]         row_index;
	logic signed [csrspmv_pkg::DATA_W-1:0] row_sum;

	// model state
	logic signed [csrspmv_pkg::DATA_W-1:0] x_store [DEPTH];
	longint                                acc = 0;
	logic [csrspmv_pkg::ROW_W-1:0]         rows_out = '0;
	logic [csrspmv_pkg::ROW_W-1:0]         first_row_cfg = '0;
	csrspmv_pkg::res_t                     expected_rows [$];

	// stimulus bookkeeping
	spmv_item_t               pending_items [$];
	bit                       loaded [DEPTH];
	int                       loaded_cols [$];
	spmv_item_t               on_bus;
	csrspmv_pkg::res_t        due;
	int                       queued_cnt = 0;
	int                       accepted_cnt = 0;
	int                       results_seen = 0;
	int                       errors = 0;
	int                       stuck = 0;
	int                       send_wait = 0;
	int                       send_run = 0;
	int                       take_wait = 0;
	int                       take_run = 0;

	csr_sparse_matrix_vector_multiply_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.command(command),
		.vector_index(vector_index),
		.vector_value(vector_value),
		.column_index(column_index),
		.entry_value(entry_value),
		.row_end(row_end),
		.empty(empty),
		.pop(pop),
		.row_index(row_index),
		.row_sum(row_sum)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int next_gap(inout int run_left);
		int r;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3)
			run_left = $urandom_range(80, 20);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic signed [csrspmv_pkg::DATA_W-1:0] rand_q();
		case ($urandom_range(9))
			0, 1, 2, 3: rand_q = csrspmv_pkg::DATA_W'(int'($urandom_range(262143)) - 131072);
			4, 5: rand_q = csrspmv_pkg::DATA_W'($urandom);
			6: rand_q = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			7: rand_q = csrspmv_pkg::DATA_W'(int'($urandom_range(2)) - 1);
			default: rand_q = csrspmv_pkg::DATA_W'(int'($urandom_range(33554431)) - 16777216);
		endcase
	endfunction

	function automatic void emit_row(longint s);
		csrspmv_pkg::res_t r;
		r.row = first_row_cfg + rows_out;
		r.sum = csrspmv_pkg::DATA_W'(s > OUT_HI ? OUT_HI : (s < OUT_LO ? OUT_LO : s));
		expected_rows.push_back(r);
		rows_out++;
		acc = 0;
	endfunction

	function automatic void predict_row_sum(spmv_item_t it);
		longint prod;
		case (it.cmd)
			csrspmv_pkg::CMD_LOAD: x_store[it.vidx] = it.vval;
			csrspmv_pkg::CMD_NONZERO: begin
				prod = longint'(it.ent) * longint'(x_store[it.col]);
				// round to nearest, ties up
				prod = (prod + 64'sd32768) >>> csrspmv_pkg::FRAC;
				acc = acc + prod;
				if (acc > ACC_HI)
					acc = ACC_HI;
				else if (acc < ACC_LO)
					acc = ACC_LO;
				if (it.last)
					emit_row(acc);
			end
			csrspmv_pkg::CMD_EMPTY: emit_row(0);
			default: ;
		endcase
	endfunction

	function automatic void add_item(logic [csrspmv_pkg::CMD_W-1:0] cmd, int index,
			logic signed [csrspmv_pkg::DATA_W-1:0] value, logic last);
		spmv_item_t it;
		it.cmd = cmd;
		it.vidx = csrspmv_pkg::IDX_W'($urandom);
		it.vval = csrspmv_pkg::DATA_W'($urandom);
		it.col = csrspmv_pkg::IDX_W'($urandom);
		it.ent = csrspmv_pkg::DATA_W'($urandom);
		it.last = 1'($urandom);
		if (cmd == csrspmv_pkg::CMD_LOAD) begin
			it.vidx = csrspmv_pkg::IDX_W'(index);
			it.vval = value;
			if (!loaded[index]) begin
				loaded[index] = 1'b1;
				loaded_cols.push_back(index);
			end
		end else if (cmd == csrspmv_pkg::CMD_NONZERO) begin
			it.col = csrspmv_pkg::IDX_W'(index);
			it.ent = value;
			it.last = last;
		end
		pending_items.push_back(it);
		queued_cnt++;
	endfunction

	function automatic int any_loaded_col();
		return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
	endfunction

	task automatic random_rows(int n);
		int made;
		int len;
		int r;
		int r2;
		bit broken;
		made = 0;
		while (made < n) begin
			r = $urandom_range(99);
			if (r < 8) begin
				add_item(csrspmv_pkg::CMD_LOAD, $urandom_range(DEPTH - 1), rand_q(), 1'b0);
				made++;
			end else if (r < 10) begin
				add_item(CMD_RESERVED, 0, '0, 1'b0);
			end else if (r < 14) begin
				add_item(csrspmv_pkg::CMD_EMPTY, 0, '0, 1'b0);
				made++;
			end else begin
				r2 = $urandom_range(99);
				len = r2 < 70 ? $urandom_range(4, 1) :
					r2 < 95 ? $urandom_range(10, 5) : $urandom_range(24, 11);
				// row cut short by an empty-row item
				broken = r < 18;
				for (int k = 0; k < len; k++)
					add_item(csrspmv_pkg::CMD_NONZERO, any_loaded_col(), rand_q(),
						!broken && k == len - 1);
				if (broken)
					add_item(csrspmv_pkg::CMD_EMPTY, 0, '0, 1'b0);
				made += len + int'(broken);
			end
		end
	endtask

	task automatic csr_xfer(input logic wr, input logic [csrspmv_pkg::ADDR_W-1:0] addr,
			input logic [csrspmv_pkg::APB_W-1:0] wdata,
			output logic [csrspmv_pkg::APB_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (wr && addr == FIRST_ROW_ADDR)
			first_row_cfg = wdata[csrspmv_pkg::ROW_W-1:0];
	endtask

	task automatic check_first_row();
		logic [csrspmv_pkg::APB_W-1:0] rd;
		csr_xfer(1'b0, FIRST_ROW_ADDR, '0, rd);
		if (rd !== csrspmv_pkg::APB_W'(first_row_cfg)) begin
			$display("%0t: first_row read expected %0h, actual %0h", $time,
				first_row_cfg, rd);
			errors++;
		end
	endtask

	task automatic set_first_row(logic [csrspmv_pkg::ROW_W-1:0] v);
		logic [csrspmv_pkg::APB_W-1:0] rd;
		csr_xfer(1'b1, FIRST_ROW_ADDR, csrspmv_pkg::APB_W'(v), rd);
		check_first_row();
	endtask

	// everything sent, every row back, then let trailing items settle
	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_row_sum(on_bus);
				accepted_cnt++;
			end
			if (!(push && full)) begin
				if (send_wait > 0) begin
					send_wait--;
					push <= 1'b0;
				end else if (pending_items.size() != 0) begin
					on_bus = pending_items.pop_front();
					command <= on_bus.cmd;
					vector_index <= on_bus.vidx;
					vector_value <= on_bus.vval;
					column_index <= on_bus.col;
					entry_value <= on_bus.ent;
					row_end <= on_bus.last;
					push <= 1'b1;
					send_wait = next_gap(send_run);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected result, row_index %0d row_sum %0d", $time,
						row_index, row_sum);
					errors++;
				end else begin
					due = expected_rows.pop_front();
					if (row_index !== due.row) begin
						$display("%0t: row_index expected %0d, actual %0d", $time,
							due.row, row_index);
						errors++;
					end
					if (row_sum !== due.sum) begin
						$display("%0t: row_sum expected %0d, actual %0d", $time,
							due.sum, row_sum);
						errors++;
					end
				end
				results_seen++;
				// one long hold-off so the block backs up to its input
				if (results_seen == HOLD_AFTER)
					take_wait = HOLD_CYCLES;
				else
					take_wait = next_gap(take_run);
			end
			if (take_wait > 0) begin
				take_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || psel)
			stuck = 0;
		else
			stuck++;
		if (stuck == WATCHDOG_LIMIT) begin
			$display("** csr_sparse_matrix_vector_multiply_top: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [csrspmv_pkg::APB_W-1:0] rd;
		logic [csrspmv_pkg::ROW_W-1:0] row_base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// rows wrap past 16 bits; write to an unmapped address is dropped
		set_first_row(16'hFFFE);
		csr_xfer(1'b1, UNMAPPED_ADDR, 32'h0000_1234, rd);
		check_first_row();

		add_item(csrspmv_pkg::CMD_LOAD, 0, 32'sh8000_0000, 1'b0);
		add_item(csrspmv_pkg::CMD_LOAD, DEPTH - 1, 32'sh7FFF_FFFF, 1'b0);
		add_item(csrspmv_pkg::CMD_LOAD, 1, 32'sh0001_0000, 1'b0);
		add_item(csrspmv_pkg::CMD_LOAD, 2, -32'sd1, 1'b0);
		add_item(csrspmv_pkg::CMD_LOAD, 512, 32'sd0, 1'b0);
		add_item(csrspmv_pkg::CMD_NONZERO, 1, 32'sh0001_8000, 1'b1);
		// accumulator saturation, both signs
		for (int k = 0; k < 3; k++)
			add_item(csrspmv_pkg::CMD_NONZERO, 0, 32'sh8000_0000, k == 2);
		for (int k = 0; k < 3; k++)
			add_item(csrspmv_pkg::CMD_NONZERO, 0, 32'sh7FFF_FFFF, k == 2);
		// half-lsb ties round upwards
		add_item(csrspmv_pkg::CMD_NONZERO, 2, 32'sh0000_8000, 1'b0);
		add_item(csrspmv_pkg::CMD_NONZERO, 2, -32'sh0000_8000, 1'b1);
		// partial sum dropped by an empty row
		add_item(csrspmv_pkg::CMD_NONZERO, DEPTH - 1, 32'sd1, 1'b0);
		add_item(csrspmv_pkg::CMD_EMPTY, 0, '0, 1'b0);
		add_item(CMD_RESERVED, 0, '0, 1'b0);
		add_item(csrspmv_pkg::CMD_NONZERO, 512, 32'sh7FFF_FFFF, 1'b1);
		add_item(csrspmv_pkg::CMD_EMPTY, 0, '0, 1'b0);
		add_item(csrspmv_pkg::CMD_NONZERO, DEPTH - 1, 32'sh7FFF_FFFF, 1'b1);
		add_item(csrspmv_pkg::CMD_NONZERO, DEPTH - 1, 32'sh8000_0000, 1'b1);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			row_base = p == 0 ? 16'h0000 : p == 1 ? 16'hFFFF :
				csrspmv_pkg::ROW_W'($urandom);
			set_first_row(row_base);
			random_rows(PHASE_ITEMS);
			wait_drained();
		end

		if (errors == 0)
			$display("** csr_sparse_matrix_vector_multiply_top: PASSED **");
		else
			$display("** csr_sparse_matrix_vector_multiply_top: FAILED **");
		$finish;
	end
endmodule
